@@ hw/rtl/lrrg_pkg.sv @@
// Package with the generator constants and the shift-register step function.
`timescale 1ns / 1ps

package lrrg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned CNT_W  = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0]  cmd_t;

	localparam word_t FULL_WORD     = 32'hFFFF_FFFF;
	localparam word_t SEED_AT_RESET = 32'h0035_6167;

	localparam cmd_t CMD_LOAD  = 2'd0;
	localparam cmd_t CMD_RAW   = 2'd1;
	localparam cmd_t CMD_RANGE = 2'd2;
	localparam cmd_t CMD_NONE  = 2'd3;

	// One step: shift right, feedback from taps 31, 6, 4, 2, 1 and 0 enters bit 31.
	function automatic word_t advance(input word_t r);
		logic fb;
		fb = r[31] ^ r[6] ^ r[4] ^ r[2] ^ r[1] ^ r[0];
		return {fb, r[WORD_W-1:1]};
	endfunction

endpackage

@@ hw/rtl/lfsr_ranged_random_generator.sv @@
// Shift-register random generator with rejection-sampled ranged draws.
//
//  channel | direction | signals                          | beat
//  --------+-----------+----------------------------------+------------------------------
//  in      | sink      | in_valid, in_ready, cmd,         | one command
//          |           | seed_value, range                |
//  out     | source    | out_valid, out_ready, value      | one result word
//
// A raw draw or a range of 0 or 1 goes straight to the final state. A
// ranged draw runs the shared one-bit-per-cycle restoring divider twice
// (for the rejection limit, then the final remainder) around generator
// steps that repeat until a word falls below that limit. in_ready is
// high only when the sequencer is idle; a finished result waits in the
// output register while the next command is taken, and the sequencer
// holds in its final state while that register still holds an untaken
// beat. Reset loads the seed 0x356167 and empties the output.
`timescale 1ns / 1ps

module lfsr_ranged_random_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lrrg_pkg::cmd_t       cmd,
	input  lrrg_pkg::word_t      seed_value,
	input  lrrg_pkg::word_t      range,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lrrg_pkg::word_t      value
);
	import lrrg_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MOD_LIM = 3'd1;
	localparam logic [2:0] ST_STEP    = 3'd2;
	localparam logic [2:0] ST_MOD_VAL = 3'd3;
	localparam logic [2:0] ST_FIN     = 3'd4;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	logic [2:0]       state_q;
	word_t            shift_state_q;
	word_t            rng_q;
	word_t            limit_q;
	word_t            rem_q;
	word_t            dvd_q;
	word_t            res_q;
	word_t            value_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             out_free;
	word_t            next_state;
	logic [WORD_W:0]  div_shift;
	logic [WORD_W:0]  div_diff;
	word_t            rem_nxt;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Next generator state.
	assign next_state = advance(shift_state_q);

	// Shared divider: one restoring step per cycle, remainder only.
	assign div_shift = {rem_q, dvd_q[WORD_W-1]};
	assign div_diff  = div_shift - {1'b0, rng_q};
	assign rem_nxt   = div_diff[WORD_W] ? div_shift[WORD_W-1:0] : div_diff[WORD_W-1:0];

	// Sequencer, generator state and divider registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			shift_state_q <= SEED_AT_RESET;
			cnt_q         <= '0;
			rng_q         <= '0;
			limit_q       <= '0;
			rem_q         <= '0;
			dvd_q         <= '0;
			res_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_LOAD: begin
								shift_state_q <= seed_value;
							end
							CMD_RAW: begin
								shift_state_q <= next_state;
								res_q         <= next_state;
								state_q       <= ST_FIN;
							end
							CMD_RANGE: begin
								rng_q <= range;
								if (range[WORD_W-1:1] == '0) begin
									res_q   <= '0;
									state_q <= ST_FIN;
								end else begin
									rem_q   <= '0;
									dvd_q   <= FULL_WORD;
									cnt_q   <= '0;
									state_q <= ST_MOD_LIM;
								end
							end
							CMD_NONE: begin
							end
						endcase
					end
				end
				ST_MOD_LIM: begin
					rem_q <= rem_nxt;
					dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						limit_q <= FULL_WORD - rem_nxt;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					// Step until the word falls below the rejection limit.
					shift_state_q <= next_state;
					if (next_state < limit_q) begin
						rem_q   <= '0;
						dvd_q   <= next_state;
						cnt_q   <= '0;
						state_q <= ST_MOD_VAL;
					end
				end
				ST_MOD_VAL: begin
					rem_q <= rem_nxt;
					dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						res_q   <= rem_nxt;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds a finished beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			value_q <= res_q;
		end
	end

endmodule
